>>> sv/mpra_pkg.sv
// Package for the multi-pool bitmap register allocator.
// Holds default sizes, mode codes, the controller state type and shared helpers.
// No dependencies.
package mpra_pkg;

  localparam int POOLS_DEF        = 4;
  localparam int REGS_DEF         = 16;
  localparam int BITMAP_BYTES_DEF = 2;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_OPEN   = 3'd2;
  localparam logic [2:0] MODE_CLOSE  = 3'd3;
  localparam logic [2:0] MODE_SWITCH = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> sv/mpra_if.sv
// Handshake channels of the allocator: request channel and result channel.
// Depends on nothing; each carries valid, ready and the item fields.
interface mpra_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [2:0] pool_index;
  logic [4:0] slot_index;
  logic       save_previous;

  modport source (output valid, mode, pool_index, slot_index, save_previous, input ready);
  modport sink   (input valid, mode, pool_index, slot_index, save_previous, output ready);
endinterface

interface mpra_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [3:0] slot_out;
  logic [1:0] pool_out;
  logic [1:0] previous_pool;
  logic       previous_valid;

  modport source (output valid, ok, slot_out, pool_out, previous_pool, previous_valid,
                  input ready);
  modport sink   (input valid, ok, slot_out, pool_out, previous_pool, previous_valid,
                  output ready);
endinterface

>>> sv/mpra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Uses mpra_pkg for the address width helper.
module mpra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [mpra_pkg::addr_bits(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [mpra_pkg::addr_bits(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import mpra_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/multi_pool_bitmap_register_allocator.sv
// Multi-pool bitmap register allocator, top level.
// Depends on mpra_pkg, mpra_in_if / mpra_out_if and mpra_ram.
//
// Usage: requests enter on in_ch (valid/ready), one result leaves on out_ch
// for every request. Modes: allocate, free, open pool, close pool, switch.
// Slot bitmaps live in a RAM with one word per pool; enable bits and a
// written flag per pool sit in flip-flops, and an unwritten word reads as zero.
// One request is in work at a time. Steps from the accepting edge until
// out_ch.valid rises, with the output register free:
//   open, close, switch, unused modes: straight to the result state
//   free: read, modify, write back
//   allocate: the scan skips each disabled pool and reads, then checks, each
//   enabled pool it visits, until it finds a word with a clear bit or runs past
//   the last pool. After a result loads, the controller returns to idle.
// in_ch.ready is high while the controller waits for a request; the next
// request is taken while a result still sits in the output register.
// If out_ch stalls, the finished result waits in the controller and no new
// request is taken until the output register frees.
// Reset clears all enable bits and written flags, so every bitmap reads zero.
module multi_pool_bitmap_register_allocator #(
  parameter int POOLS        = mpra_pkg::POOLS_DEF,
  parameter int REGS         = mpra_pkg::REGS_DEF,
  parameter int BITMAP_BYTES = mpra_pkg::BITMAP_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mpra_in_if.sink    in_ch,
  mpra_out_if.source out_ch
);
  import mpra_pkg::*;

  localparam int MAP_BITS = BITMAP_BYTES * 8;
  localparam int AW       = addr_bits(POOLS);
  localparam int SW       = $clog2(POOLS + 1);
  localparam int IW       = $clog2(MAP_BITS);

  state_t state_r, state_nxt;

  logic [2:0]    mode_r, mode_nxt;
  logic [4:0]    sidx_r, sidx_nxt;
  logic [SW-1:0] scan_r, scan_nxt;

  logic [POOLS-1:0] en_r, en_nxt;
  logic [POOLS-1:0] wr_r, wr_nxt;

  logic       res_ok_r, res_ok_nxt;
  logic [3:0] res_slot_r, res_slot_nxt;
  logic [1:0] res_pool_r, res_pool_nxt;
  logic [1:0] res_prev_r, res_prev_nxt;
  logic       res_prev_v_r, res_prev_v_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_ok_r, out_ok_nxt;
  logic [3:0] out_slot_r, out_slot_nxt;
  logic [1:0] out_pool_r, out_pool_nxt;
  logic [1:0] out_prev_r, out_prev_nxt;
  logic       out_prev_v_r, out_prev_v_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [MAP_BITS-1:0] ram_wdata, ram_rdata;

  logic                acc, pidx_ok, free_ok, en_sel, open_found;
  logic [AW-1:0]       open_idx;
  logic                scan_done, scan_en, map_full, id_ok, out_load;
  logic [MAP_BITS-1:0] cur_map;
  logic [IW-1:0]       free_id;

  mpra_ram #(.WIDTH(MAP_BITS), .DEPTH(POOLS)) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign pidx_ok     = ({1'b0, in_ch.pool_index} < 4'(POOLS));
  assign free_ok     = pidx_ok && (6'(in_ch.slot_index) < 6'(REGS))
                       && (6'(in_ch.slot_index) < 6'(MAP_BITS));
  assign en_sel      = en_r[in_ch.pool_index[AW-1:0]];
  assign scan_done   = (scan_r == SW'(POOLS));
  assign scan_en     = en_r[scan_r[AW-1:0]];
  assign cur_map     = wr_r[scan_r[AW-1:0]] ? ram_rdata : '0;
  assign id_ok       = (6'(free_id) < 6'(REGS));
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    open_found = 1'b0;
    open_idx   = '0;
    for (int i = POOLS - 1; i >= 0; i--) begin
      if (!en_r[i]) begin
        open_found = 1'b1;
        open_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    map_full = 1'b1;
    for (int b = 0; b < BITMAP_BYTES; b++) begin
      if (cur_map[8*b +: 8] != BYTE_FULL) begin
        map_full = 1'b0;
      end
    end
    free_id = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (!cur_map[i]) begin
        free_id = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.mode == MODE_ALLOC || (in_ch.mode == MODE_FREE && free_ok)) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        if (mode_r == MODE_FREE) begin
          state_nxt = ST_CHECK;
        end else if (scan_done) begin
          state_nxt = ST_DONE;
        end else if (scan_en) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (mode_r == MODE_ALLOC && map_full) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    sidx_nxt       = sidx_r;
    scan_nxt       = scan_r;
    en_nxt         = en_r;
    wr_nxt         = wr_r;
    res_ok_nxt     = res_ok_r;
    res_slot_nxt   = res_slot_r;
    res_pool_nxt   = res_pool_r;
    res_prev_nxt   = res_prev_r;
    res_prev_v_nxt = res_prev_v_r;
    ram_we         = 1'b0;
    ram_waddr      = scan_r[AW-1:0];
    ram_wdata      = '0;
    ram_re         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          mode_nxt       = in_ch.mode;
          sidx_nxt       = in_ch.slot_index;
          scan_nxt       = (in_ch.mode == MODE_FREE) ? SW'(in_ch.pool_index) : '0;
          res_ok_nxt     = 1'b0;
          res_slot_nxt   = '0;
          res_pool_nxt   = '0;
          res_prev_nxt   = '0;
          res_prev_v_nxt = 1'b0;
          case (in_ch.mode)
            MODE_OPEN: begin
              if (open_found) begin
                en_nxt[open_idx] = 1'b1;
                wr_nxt[open_idx] = 1'b1;
                ram_we           = 1'b1;
                ram_waddr        = open_idx;
                res_ok_nxt       = 1'b1;
                res_pool_nxt     = 2'(open_idx);
              end
            end
            MODE_CLOSE: begin
              if (pidx_ok && en_sel) begin
                en_nxt[in_ch.pool_index[AW-1:0]] = 1'b0;
                res_ok_nxt                       = 1'b1;
              end
            end
            MODE_SWITCH: begin
              if (pidx_ok && en_sel) begin
                if (in_ch.save_previous && open_found) begin
                  en_nxt[open_idx] = 1'b1;
                  wr_nxt[open_idx] = 1'b1;
                  ram_we           = 1'b1;
                  ram_waddr        = open_idx;
                  res_prev_nxt     = 2'(open_idx);
                  res_prev_v_nxt   = 1'b1;
                end
                en_nxt[in_ch.pool_index[AW-1:0]] = 1'b0;
                res_ok_nxt                       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (mode_r == MODE_FREE) begin
          ram_re = 1'b1;
        end else if (!scan_done) begin
          if (scan_en) begin
            ram_re = 1'b1;
          end else begin
            scan_nxt = scan_r + SW'(1);
          end
        end
      end
      ST_CHECK: begin
        if (mode_r == MODE_FREE) begin
          ram_we     = 1'b1;
          ram_wdata  = cur_map & ~(MAP_BITS'(1) << sidx_r[IW-1:0]);
          wr_nxt[scan_r[AW-1:0]] = 1'b1;
          res_ok_nxt = 1'b1;
        end else if (map_full) begin
          scan_nxt = scan_r + SW'(1);
        end else if (id_ok) begin
          ram_we       = 1'b1;
          ram_wdata    = cur_map | (MAP_BITS'(1) << free_id);
          wr_nxt[scan_r[AW-1:0]] = 1'b1;
          res_ok_nxt   = 1'b1;
          res_slot_nxt = 4'(free_id);
          res_pool_nxt = 2'(scan_r);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_ok_nxt     = out_ok_r;
    out_slot_nxt   = out_slot_r;
    out_pool_nxt   = out_pool_r;
    out_prev_nxt   = out_prev_r;
    out_prev_v_nxt = out_prev_v_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_ok_nxt     = res_ok_r;
      out_slot_nxt   = res_slot_r;
      out_pool_nxt   = res_pool_r;
      out_prev_nxt   = res_prev_r;
      out_prev_v_nxt = res_prev_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      en_r        <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    sidx_r       <= sidx_nxt;
    scan_r       <= scan_nxt;
    res_ok_r     <= res_ok_nxt;
    res_slot_r   <= res_slot_nxt;
    res_pool_r   <= res_pool_nxt;
    res_prev_r   <= res_prev_nxt;
    res_prev_v_r <= res_prev_v_nxt;
    out_ok_r     <= out_ok_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pool_r   <= out_pool_nxt;
    out_prev_r   <= out_prev_nxt;
    out_prev_v_r <= out_prev_v_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.slot_out       = out_slot_r;
  assign out_ch.pool_out       = out_pool_r;
  assign out_ch.previous_pool  = out_prev_r;
  assign out_ch.previous_valid = out_prev_v_r;

endmodule
